// File: rtl/dbpt_pkg.sv
// shared constants and types of the depth bucket priority tracker
`default_nettype none

package dbpt_pkg;

  localparam int MaxNodesDef  = 256;
  localparam int MaxDepthDef  = 256;
  localparam int MaxStatesDef = 8;

  localparam int FieldW   = 8;
  localparam int CfgW     = 4;
  localparam int LiveW    = 7;
  localparam int InDataW  = 32;
  localparam int OutDataW = 24;

  localparam logic [FieldW-1:0] TagNone      = 8'hFF;
  localparam logic [CfgW-1:0]   TrackedReset = 4'd1;

  typedef enum logic [2:0] {
    FuncSetState    = 3'd0,
    FuncDepthChange = 3'd1,
    FuncDestroy     = 3'd2,
    FuncGetState    = 3'd3,
    FuncPopTop      = 3'd4,
    FuncPopBottom   = 3'd5
  } func_e;

endpackage

`default_nettype wire

// File: rtl/dbpt_ram.sv
// single write port, single read port memory with registered read data
`default_nettype none

module dbpt_ram #(
  parameter int Width = dbpt_pkg::FieldW,
  parameter int Depth = dbpt_pkg::MaxNodesDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/depth_bucket_priority_tracker.sv
// Depth bucket priority tracker: node tag/depth tables with min/max pop by scan.
// Input beats arrive on the s_axis group, one command per beat; every command
// gives exactly one result beat on the m_axis group.
// tracked_states is written through cfg_we_i/cfg_wdata_i; the user must do so
// only while the block is idle, which the block itself does not enforce; tags
// below min(tracked_states, MAX_STATES) are queued, the rest are only stored.
// set_state, depth_change, destroy, unused codes and pops of an untracked tag
// go straight to the result; get_state reads the tag memory first; pops scan.
// A pop walks the tag and depth memories one entry a cycle through their single
// read port, so pop throughput is set by MAX_NODES; the block takes one command
// at a time and s_axis_tready is high only between commands.
// After reset the tag memory is swept to none, one entry a cycle, over all
// MAX_NODES entries; s_axis_tready stays low during the sweep, configuration
// writes are still taken and tracked_states resets to 1.
// The result sits in an output register; a stalled receiver holds it there while
// the next command is accepted and processed, and that command's result waits
// until the register is free.
`default_nettype none

module depth_bucket_priority_tracker #(
  parameter int MAX_NODES  = dbpt_pkg::MaxNodesDef,
  parameter int MAX_DEPTH  = dbpt_pkg::MaxDepthDef,
  parameter int MAX_STATES = dbpt_pkg::MaxStatesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dbpt_pkg::CfgW-1:0]     cfg_wdata_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // func[2:0], node_id[10:3], node_depth[18:11], state_tag[26:19], zero pad
  input  wire logic [dbpt_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // result_node[7:0], result_tag[15:8], found[16], zero pad
  output logic      [dbpt_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int NW     = $clog2(MAX_NODES);
  localparam int DW     = $clog2(MAX_DEPTH);
  localparam int IW     = (NW > dbpt_pkg::FieldW) ? NW : dbpt_pkg::FieldW;
  localparam int DXW    = (DW > dbpt_pkg::FieldW) ? DW : dbpt_pkg::FieldW;
  localparam int FW     = dbpt_pkg::FieldW;
  localparam int LiveWc = dbpt_pkg::LiveW;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StRead,
    StScan,
    StPopWr,
    StResp
  } state_e;

  state_e state_q;

  logic [dbpt_pkg::CfgW-1:0] tracked_q;
  logic [NW:0]               cnt_q;
  logic [NW-1:0]             rd_idx_q;
  logic [FW-1:0]             op_tag_q;
  logic                      op_max_q;
  logic                      have_q;
  logic [NW-1:0]             best_id_q;
  logic [DW-1:0]             best_d_q;
  logic [FW-1:0]             res_node_q;
  logic [FW-1:0]             res_tag_q;
  logic                      res_found_q;
  logic                      m_valid_q;
  logic [FW-1:0]             m_node_q;
  logic [FW-1:0]             m_tag_q;
  logic                      m_found_q;

  // input fields
  dbpt_pkg::func_e in_func;
  logic [FW-1:0]   in_node;
  logic [FW-1:0]   in_depth;
  logic [FW-1:0]   in_tag;
  logic [IW-1:0]   node_ext;
  logic [DXW-1:0]  depth_ext;
  logic [NW-1:0]   node_sat;
  logic [DW-1:0]   depth_sat;
  logic [LiveWc-1:0] live_cnt;
  logic            tag_live;
  logic            s_fire;
  logic            out_free;
  logic            out_load;

  assign in_func  = dbpt_pkg::func_e'(s_axis_tdata[2:0]);
  assign in_node  = s_axis_tdata[10:3];
  assign in_depth = s_axis_tdata[18:11];
  assign in_tag   = s_axis_tdata[26:19];

  assign node_ext  = IW'(in_node);
  assign depth_ext = DXW'(in_depth);
  assign node_sat  = (node_ext >= IW'(MAX_NODES - 1)) ? NW'(MAX_NODES - 1) : NW'(node_ext);
  assign depth_sat = (depth_ext >= DXW'(MAX_DEPTH - 1)) ? DW'(MAX_DEPTH - 1) : DW'(depth_ext);

  assign live_cnt = (LiveWc'(tracked_q) > LiveWc'(MAX_STATES)) ? LiveWc'(MAX_STATES)
                                                              : LiveWc'(tracked_q);
  assign tag_live = in_tag < FW'(live_cnt);

  assign s_axis_tready = (state_q == StIdle);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign out_load      = (state_q == StResp) && out_free;

  // memory ports
  logic          tag_we;
  logic [NW-1:0] tag_waddr;
  logic [FW-1:0] tag_wdata;
  logic          dep_we;
  logic [NW-1:0] raddr;
  logic [FW-1:0] tag_rd;
  logic [DW-1:0] dep_rd;

  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = node_sat;
    tag_wdata = dbpt_pkg::TagNone;
    dep_we    = 1'b0;
    raddr     = cnt_q[NW-1:0];
    case (state_q)
      StClear: begin
        tag_we    = 1'b1;
        tag_waddr = cnt_q[NW-1:0];
      end
      StIdle: begin
        raddr = node_sat;
        if (s_fire) begin
          case (in_func)
            dbpt_pkg::FuncSetState: begin
              tag_we    = 1'b1;
              tag_wdata = in_tag;
              dep_we    = 1'b1;
            end
            dbpt_pkg::FuncDepthChange: begin
              dep_we = 1'b1;
            end
            dbpt_pkg::FuncDestroy: begin
              tag_we = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      StPopWr: begin
        tag_we    = have_q;
        tag_waddr = best_id_q;
      end
      default: begin
      end
    endcase
  end

  dbpt_ram #(
    .Width(FW),
    .Depth(MAX_NODES)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(tag_waddr),
    .wdata_i(tag_wdata),
    .raddr_i(raddr),
    .rdata_o(tag_rd)
  );

  dbpt_ram #(
    .Width(DW),
    .Depth(MAX_NODES)
  ) u_depth_ram (
    .clk_i  (clk_i),
    .we_i   (dep_we),
    .waddr_i(node_sat),
    .wdata_i(depth_sat),
    .raddr_i(raddr),
    .rdata_o(dep_rd)
  );

  // scan compare on the entry read last cycle
  logic better;
  assign better = (cnt_q != '0) && (tag_rd == op_tag_q) &&
                  (!have_q || (op_max_q ? (dep_rd > best_d_q) : (dep_rd < best_d_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_q <= dbpt_pkg::TrackedReset;
    end else if (cfg_we_i) begin
      tracked_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      op_tag_q    <= '0;
      op_max_q    <= 1'b0;
      have_q      <= 1'b0;
      best_id_q   <= '0;
      best_d_q    <= '0;
      res_node_q  <= '0;
      res_tag_q   <= dbpt_pkg::TagNone;
      res_found_q <= 1'b0;
      m_valid_q   <= 1'b0;
      m_node_q    <= '0;
      m_tag_q     <= dbpt_pkg::TagNone;
      m_found_q   <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          if (cnt_q == (NW + 1)'(MAX_NODES - 1)) begin
            cnt_q   <= '0;
            state_q <= StIdle;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StIdle: begin
          if (s_fire) begin
            res_node_q  <= '0;
            res_tag_q   <= dbpt_pkg::TagNone;
            res_found_q <= 1'b0;
            op_tag_q    <= in_tag;
            have_q      <= 1'b0;
            cnt_q       <= '0;
            case (in_func)
              dbpt_pkg::FuncGetState: begin
                state_q <= StRead;
              end
              dbpt_pkg::FuncPopTop, dbpt_pkg::FuncPopBottom: begin
                op_max_q <= (in_func == dbpt_pkg::FuncPopBottom);
                state_q  <= tag_live ? StScan : StResp;
              end
              default: begin
                state_q <= StResp;
              end
            endcase
          end
        end
        StRead: begin
          res_tag_q <= tag_rd;
          state_q   <= StResp;
        end
        StScan: begin
          rd_idx_q <= cnt_q[NW-1:0];
          if (better) begin
            have_q    <= 1'b1;
            best_id_q <= rd_idx_q;
            best_d_q  <= dep_rd;
          end
          if (cnt_q == (NW + 1)'(MAX_NODES)) begin
            state_q <= StPopWr;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StPopWr: begin
          res_found_q <= have_q;
          res_node_q  <= have_q ? FW'(best_id_q) : '0;
          state_q     <= StResp;
        end
        StResp: begin
          if (out_free) begin
            m_node_q  <= res_node_q;
            m_tag_q   <= res_tag_q;
            m_found_q <= res_found_q;
            state_q   <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_found_q, m_tag_q, m_node_q};

endmodule

`default_nettype wire

// File: rtl/dbpt_checker.sv
// port-level checks of the depth bucket priority tracker, bound to the top level
`default_nettype none

module dbpt_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [dbpt_pkg::OutDataW-1:0] m_axis_tdata
);

  // result beat stays up until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // stalled result keeps its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // an empty pop and every non-pop command return node zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[7:0] == '0)
    else $error("node reported without found");

  // a popped node never carries a read tag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[15:8] == dbpt_pkg::TagNone)
    else $error("found result with a tag");

  // one command at a time: an accepted beat drops ready in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken back to back");

endmodule

bind depth_bucket_priority_tracker dbpt_checker u_dbpt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
